FILE: rtl/tal_pkg.sv
package tal_pkg;

  typedef struct packed {
    logic [15:0] char_code;
    logic        end_of_text;
  } tal_in_t;

  typedef struct packed {
    logic [15:0] char_echo;
    logic [1:0]  role;
    logic        starts_pair;
    logic        prior_pair_done;
    logic        final_pair_done;
    logic        header_done;
  } tal_out_t;

  typedef enum logic [2:0] {
    ST_BETWEEN   = 3'd0,
    ST_KEY       = 3'd1,
    ST_AFTER_KEY = 3'd2,
    ST_AFTER_EQ  = 3'd3,
    ST_QVAL      = 3'd4,
    ST_QCLOSED   = 3'd5,
    ST_UVAL      = 3'd6,
    ST_DONE      = 3'd7
  } lex_state_e;

  localparam logic [1:0] ROLE_SKIP  = 2'd0;
  localparam logic [1:0] ROLE_KEY   = 2'd1;
  localparam logic [1:0] ROLE_VALUE = 2'd2;

  localparam logic [15:0] CH_EQ    = 16'h003D;
  localparam logic [15:0] CH_SLASH = 16'h002F;
  localparam logic [15:0] CH_GT    = 16'h003E;
  localparam logic [15:0] CH_DQ    = 16'h0022;
  localparam logic [15:0] CH_SQ    = 16'h0027;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_CR    = 16'h000D;

endpackage

FILE: rtl/tal_lex_core.sv
module tal_lex_core
  import tal_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  tal_in_t  item_i,
  output tal_out_t res_o
);

  lex_state_e state_q, state_d;
  logic       quote_single_q, quote_single_d;
  logic       is_ws, is_end_mark, begin_tok;
  logic [15:0] c;

  assign c           = item_i.char_code;
  assign is_ws       = (c inside {CH_SPACE, [CH_TAB:CH_CR]});
  assign is_end_mark = (c == CH_SLASH) || (c == CH_GT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_BETWEEN;
      quote_single_q <= 1'b0;
    end else if (advance_i) begin
      state_q        <= state_d;
      quote_single_q <= quote_single_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    quote_single_d  = quote_single_q;
    begin_tok       = 1'b0;
    res_o           = '0;
    res_o.char_echo = c;
    res_o.role      = ROLE_SKIP;

    case (state_q)
      ST_BETWEEN: begin
        if (!is_ws) begin
          begin_tok = 1'b1;
        end
      end
      ST_KEY: begin
        if (c == CH_EQ) begin
          state_d = ST_AFTER_EQ;
        end else if (is_ws) begin
          state_d = ST_AFTER_KEY;
        end else begin
          res_o.role = ROLE_KEY;
        end
      end
      ST_AFTER_KEY: begin
        if (is_ws) begin
          state_d = ST_AFTER_KEY;
        end else if (c == CH_EQ) begin
          state_d = ST_AFTER_EQ;
        end else begin
          res_o.prior_pair_done = 1'b1;
          begin_tok             = 1'b1;
        end
      end
      ST_AFTER_EQ: begin
        if (is_ws) begin
          state_d = ST_AFTER_EQ;
        end else if ((c == CH_DQ) || (c == CH_SQ)) begin
          quote_single_d = (c == CH_SQ);
          state_d        = ST_QVAL;
        end else if (is_end_mark) begin
          res_o.prior_pair_done = 1'b1;
          res_o.header_done     = 1'b1;
          state_d               = ST_DONE;
        end else begin
          res_o.role = ROLE_VALUE;
          state_d    = ST_UVAL;
        end
      end
      ST_QVAL: begin
        if (c == (quote_single_q ? CH_SQ : CH_DQ)) begin
          state_d = ST_QCLOSED;
        end else begin
          res_o.role = ROLE_VALUE;
        end
      end
      ST_QCLOSED: begin
        res_o.prior_pair_done = 1'b1;
        if (is_ws) begin
          state_d = ST_BETWEEN;
        end else begin
          begin_tok = 1'b1;
        end
      end
      ST_UVAL: begin
        if (is_ws) begin
          res_o.prior_pair_done = 1'b1;
          state_d               = ST_BETWEEN;
        end else if (is_end_mark) begin
          res_o.prior_pair_done = 1'b1;
          res_o.header_done     = 1'b1;
          state_d               = ST_DONE;
        end else begin
          res_o.role = ROLE_VALUE;
        end
      end
      default: begin
        state_d = state_q;
      end
    endcase

    if (begin_tok) begin
      if (is_end_mark) begin
        res_o.header_done = 1'b1;
        state_d           = ST_DONE;
      end else if (c == CH_EQ) begin
        res_o.starts_pair = 1'b1;
        state_d           = ST_AFTER_EQ;
      end else begin
        res_o.starts_pair = 1'b1;
        res_o.role        = ROLE_KEY;
        state_d           = ST_KEY;
      end
    end

    if (item_i.end_of_text) begin
      res_o.final_pair_done = (state_d != ST_BETWEEN) && (state_d != ST_DONE);
      state_d               = ST_BETWEEN;
      quote_single_d        = 1'b0;
    end
  end

  // A header end that is not also the last character parks the lexer.
  a_header_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res_o.header_done && !item_i.end_of_text |=> state_q == ST_DONE)
    else $error("header end did not park the lexer");

  // Once parked, characters carry no role and no flags.
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> res_o.role == ROLE_SKIP && !res_o.starts_pair &&
      !res_o.prior_pair_done && !res_o.header_done)
    else $error("character after header end was classified");

  // The last character of a string returns the lexer to its reset state.
  a_eot_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.end_of_text |=> state_q == ST_BETWEEN && !quote_single_q)
    else $error("end of text did not reset the lexer");

  // A character never both opens a pair and belongs to a value.
  a_start_not_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.starts_pair |-> res_o.role != ROLE_VALUE && !res_o.header_done)
    else $error("pair start carries a value role or header end");

endmodule

FILE: rtl/tag_attribute_lexer.sv
// Streaming lexer for the attribute list of a markup tag. Each input beat carries one
// character and an end-of-text flag; each output beat echoes it with its role (skipped,
// key or value) and pair and header-end flags. One character is taken every cycle while
// the output is not stalled. A taken input beat is held in the input register and then moves
// into the result register, from which it is offered on the output; the lexer state
// advances as the character moves into the result register.
module tag_attribute_lexer
  import tal_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tal_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tal_out_t out_data_o
);

  logic     in_valid_q;
  tal_in_t  in_data_q;
  logic     out_valid_q;
  tal_out_t out_data_q;
  tal_out_t res;
  logic     advance, in_take;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
  end

  tal_lex_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_data_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
